>>> rtl/dsf_pkg.sv
// shared types and constants for the divergence swirl field block
// no dependencies; imported by every module of the block
package dsf_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int FRAC_BITS     = 8;
	localparam int BLEND_BITS    = 16;
	localparam int STRENGTH_FRAC = 12;
	localparam int DIV_CYCLES    = 8;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [1:0] OP_CLEAR     = 2'd0;
	localparam logic [1:0] OP_MEASURE   = 2'd1;
	localparam logic [1:0] OP_TRANSFORM = 2'd2;

	localparam logic [16:0] BLEND_ONE      = 17'(1 << BLEND_BITS);
	localparam logic [17:0] SMOOTH_THREE   = 18'(3 * (1 << BLEND_BITS));
	localparam logic [15:0] PEAK_DEFAULT   = 16'(1 << FRAC_BITS);
	localparam logic [15:0] STRENGTH_RESET = 16'd4096;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] divergence;
		logic               pixel_valid;
	} dsf_pix_t;

	typedef struct packed {
		logic signed [15:0] swirl_x;
		logic signed [15:0] swirl_y;
		logic [16:0]        blend;
	} dsf_res_t;

	// one transform job, classified by the front part
	typedef struct packed {
		logic        valid;
		logic [15:0] mag_d;
		logic [15:0] peak;
		logic        neg_x;
		logic [15:0] mag_x;
		logic        neg_y;
		logic [15:0] mag_y;
	} dsf_job_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_DIV,
		BK_SQ,
		BK_SMOOTH,
		BK_GAIN,
		BK_CLAMP,
		BK_SWX,
		BK_SWY,
		BK_DONE
	} dsf_bk_state_t;

endpackage

>>> rtl/divergence_swirl_field_core.sv
// Swirl field generator over a pixel stream. Clear and measure items update
// the stored divergence peak in the front part and are taken one per cycle
// while the two-entry job queue has room. A transform item for a usable pixel
// passes through the back part in order: a step to take the job, the
// two-bit-a-cycle divider (skipped when the pixel's divergence reaches the
// peak), then five passes through the one shared 18x17 multiplier, a clamp
// step and a final output step. A masked pixel goes from the step that takes
// the job straight to the output step. The output register lets the next job
// start while a result waits. The strength register may be written only while
// no transform is in flight.
// depends on dsf_pkg, dsf_front, dsf_queue, dsf_back
module divergence_swirl_field_core
	import dsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  dsf_pix_t    pix,
	output logic        res_valid,
	input  logic        res_stall,
	output dsf_res_t    res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic     queue_full;
	logic     job_push;
	dsf_job_t job_in;
	logic     job_avail;
	logic     job_pop;
	dsf_job_t job_head;

	dsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix        (pix),
		.queue_full (queue_full),
		.job_push   (job_push),
		.job        (job_in)
	);

	dsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (queue_full),
		.pop       (job_pop),
		.avail     (job_avail),
		.head      (job_head)
	);

	dsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.job_avail (job_avail),
		.job       (job_head),
		.job_pop   (job_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

>>> rtl/dsf_front.sv
// front part: accepts pixel items, keeps the divergence peak, builds transform jobs
// depends on dsf_pkg
module dsf_front
	import dsf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pix_valid,
	output logic     pix_stall,
	input  dsf_pix_t pix,
	input  logic     queue_full,
	output logic     job_push,
	output dsf_job_t job
);

	logic [15:0] peak_q;
	logic        accept;
	logic [15:0] mag_d;
	logic        d_neg;
	logic        vx_pos;
	logic        vx_neg;
	logic        vy_pos;
	logic        vy_neg;

	function automatic logic [15:0] abs16(input logic [15:0] v);
		abs16 = v[15] ? (~v + 16'd1) : v;
	endfunction

	assign pix_stall = queue_full;
	assign accept    = pix_valid && !pix_stall;
	assign job_push  = accept && (pix.opcode == OP_TRANSFORM);

	assign mag_d  = abs16(pix.divergence);
	assign d_neg  = pix.divergence[15];
	assign vx_neg = pix.vel_x[15];
	assign vy_neg = pix.vel_y[15];
	assign vx_pos = !pix.vel_x[15] && (pix.vel_x != 16'sd0);
	assign vy_pos = !pix.vel_y[15] && (pix.vel_y != 16'sd0);

	// quarter turn: (-vy, vx) for non-negative divergence, (vy, -vx) otherwise
	always_comb begin
		job.valid = pix.pixel_valid;
		job.mag_d = mag_d;
		job.peak  = (peak_q == 16'd0) ? PEAK_DEFAULT : peak_q;
		job.mag_x = abs16(pix.vel_y);
		job.mag_y = abs16(pix.vel_x);
		job.neg_x = d_neg ? vy_neg : vy_pos;
		job.neg_y = d_neg ? vx_pos : vx_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= 16'd0;
		end else if (accept) begin
			case (pix.opcode)
				OP_CLEAR: begin
					peak_q <= 16'd0;
				end
				OP_MEASURE: begin
					if (mag_d > peak_q) begin
						peak_q <= mag_d;
					end
				end
				default: begin
					peak_q <= peak_q;
				end
			endcase
		end
	end

endmodule

>>> rtl/dsf_queue.sv
// short job queue between the front and back parts
// depends on dsf_pkg
module dsf_queue
	import dsf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  dsf_job_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     avail,
	output dsf_job_t head
);

	dsf_job_t    mem_q [QUEUE_DEPTH];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full  = (count_q == 2'(QUEUE_DEPTH));
	assign avail = (count_q != 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/dsf_back.sv
// back part: divider, smoothstep and scaling sequencer with the output register
// depends on dsf_pkg; holds the strength register
module dsf_back
	import dsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        job_avail,
	input  dsf_job_t    job,
	output logic        job_pop,
	output logic        res_valid,
	input  logic        res_stall,
	output dsf_res_t    res
);

	dsf_bk_state_t state_q;
	dsf_bk_state_t state_d;

	logic [15:0] strength_q;
	logic        valid_q;
	logic [15:0] peak_q;
	logic        neg_x_q;
	logic [15:0] mag_x_q;
	logic        neg_y_q;
	logic [15:0] mag_y_q;
	logic [15:0] rem_q;
	logic [15:0] quot_q;
	logic [2:0]  cnt_q;
	logic [16:0] n_q;
	logic [34:0] prod_q;
	logic [16:0] blend_q;
	logic signed [15:0] sx_q;
	logic        res_valid_q;
	dsf_res_t    res_q;

	logic        mul_en;
	logic [17:0] mul_a;
	logic [16:0] mul_b;
	logic        res_load;
	logic        res_free;
	logic        div_last;

	logic [16:0] t1;
	logic [16:0] t2;
	logic [16:0] r1;
	logic [16:0] r2;
	logic        ge1;
	logic        ge2;
	logic [15:0] quot_d;
	logic [20:0] blend_raw;
	logic signed [15:0] sy;

	// floor of (+/-p) / ONE, saturated to the signed sample range
	function automatic logic signed [15:0] scale_sat(input logic [34:0] p, input logic neg);
		logic [16:0] q;
		logic [32:0] up;
		logic [16:0] c;
		logic [16:0] nc;
		q  = p[32:16];
		up = p[32:0] + 33'h0FFFF;
		c  = up[32:16];
		nc = ~c + 17'd1;
		if (neg) begin
			scale_sat = nc[15:0];
		end else if (q > 17'd32767) begin
			scale_sat = 16'sh7FFF;
		end else begin
			scale_sat = q[15:0];
		end
	endfunction

	assign res_free = !res_valid_q || !res_stall;
	assign div_last = (cnt_q == 3'(DIV_CYCLES - 1));

	// restoring divide, two quotient bits a cycle
	always_comb begin
		t1     = {rem_q, 1'b0};
		ge1    = (t1 >= {1'b0, peak_q});
		r1     = ge1 ? (t1 - {1'b0, peak_q}) : t1;
		t2     = {r1[15:0], 1'b0};
		ge2    = (t2 >= {1'b0, peak_q});
		r2     = ge2 ? (t2 - {1'b0, peak_q}) : t2;
		quot_d = {quot_q[13:0], ge1, ge2};
	end

	assign blend_raw = prod_q[32:12];
	assign sy        = scale_sat(prod_q, neg_y_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (job_avail) begin
					if (!job.valid) begin
						state_d = BK_DONE;
					end else if (job.mag_d >= job.peak) begin
						state_d = BK_SQ;
					end else begin
						state_d = BK_DIV;
					end
				end
			end
			BK_DIV: begin
				if (div_last) begin
					state_d = BK_SQ;
				end
			end
			BK_SQ:     state_d = BK_SMOOTH;
			BK_SMOOTH: state_d = BK_GAIN;
			BK_GAIN:   state_d = BK_CLAMP;
			BK_CLAMP:  state_d = BK_SWX;
			BK_SWX:    state_d = BK_SWY;
			BK_SWY:    state_d = BK_DONE;
			BK_DONE: begin
				if (res_free) begin
					state_d = BK_IDLE;
				end
			end
			default:   state_d = BK_IDLE;
		endcase
	end

	// shared multiplier operands and control strobes
	always_comb begin
		job_pop  = 1'b0;
		mul_en   = 1'b0;
		mul_a    = 18'd0;
		mul_b    = 17'd0;
		res_load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				job_pop = job_avail;
			end
			BK_SQ: begin
				mul_en = 1'b1;
				mul_a  = {1'b0, n_q};
				mul_b  = n_q;
			end
			BK_SMOOTH: begin
				mul_en = 1'b1;
				mul_a  = SMOOTH_THREE - {n_q, 1'b0};
				mul_b  = prod_q[32:16];
			end
			BK_GAIN: begin
				mul_en = 1'b1;
				mul_a  = {2'b00, strength_q};
				mul_b  = prod_q[32:16];
			end
			BK_SWX: begin
				mul_en = 1'b1;
				mul_a  = {2'b00, mag_x_q};
				mul_b  = blend_q;
			end
			BK_SWY: begin
				mul_en = 1'b1;
				mul_a  = {2'b00, mag_y_q};
				mul_b  = blend_q;
			end
			BK_DONE: begin
				res_load = res_free;
			end
			default: begin
				job_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			strength_q  <= STRENGTH_RESET;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				strength_q <= cfg_wdata;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			valid_q <= job.valid;
			peak_q  <= job.peak;
			neg_x_q <= job.neg_x;
			mag_x_q <= job.mag_x;
			neg_y_q <= job.neg_y;
			mag_y_q <= job.mag_y;
			rem_q   <= job.mag_d;
			quot_q  <= 16'd0;
			cnt_q   <= 3'd0;
			n_q     <= BLEND_ONE;
		end
		if (state_q == BK_DIV) begin
			rem_q  <= r2[15:0];
			quot_q <= quot_d;
			cnt_q  <= cnt_q + 3'd1;
			n_q    <= {1'b0, quot_d};
		end
		if (mul_en) begin
			prod_q <= 35'(mul_a * mul_b);
		end
		if (state_q == BK_CLAMP) begin
			blend_q <= (blend_raw > {4'd0, BLEND_ONE}) ? BLEND_ONE : blend_raw[16:0];
		end
		if (state_q == BK_SWY) begin
			sx_q <= scale_sat(prod_q, neg_x_q);
		end
		if (res_load) begin
			if (valid_q) begin
				res_q.swirl_x <= sx_q;
				res_q.swirl_y <= sy;
				res_q.blend   <= blend_q;
			end else begin
				res_q <= '0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> dv/divergence_swirl_field_core_test.sv
// self-checking bench for divergence_swirl_field_core: directed and random pixel streams with a
// cycle-free prediction of swirl and blend, checked per transfer
// depends on dsf_pkg and the core rtl
`timescale 1ns / 100ps

module divergence_swirl_field_core_test;
	import dsf_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SEG_ITEMS = 305;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_AT = 200;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        pix_valid = 1'b0;
	logic        pix_stall;
	dsf_pix_t    pix = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	dsf_res_t    res;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	// prediction state
	logic [15:0] gain_q12 = STRENGTH_RESET;
	logic [15:0] peak_level = '0;
	dsf_res_t    swirl_due[$];

	dsf_pix_t    pending[$];
	int          n_offered = 0;
	int          n_taken = 0;
	int          n_err = 0;
	int          send_idle = 17;
	int          recv_idle = 60;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	divergence_swirl_field_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic logic [15:0] sat16(input longint v);
		if (v > 32767)
			return 16'h7FFF;
		if (v < -32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	task automatic track_pixel(input dsf_pix_t p);
		longint   unit, mag_d, pk, n, n2, s, bl, px, py;
		dsf_res_t r;
		unit = longint'(1) << BLEND_BITS;
		mag_d = (p.divergence < 0) ? -longint'(p.divergence) : longint'(p.divergence);
		case (p.opcode)
			OP_CLEAR: peak_level = '0;
			OP_MEASURE: if (mag_d > peak_level) peak_level = mag_d[15:0];
			OP_TRANSFORM: begin
				if (!p.pixel_valid) begin
					r = '0;
				end else begin
					pk = (peak_level != 0) ? peak_level : PEAK_DEFAULT;
					n = (mag_d << BLEND_BITS) / pk;
					if (n > unit)
						n = unit;
					n2 = (n * n) >>> BLEND_BITS;
					s = (n2 * (3 * unit - 2 * n)) >>> BLEND_BITS;
					bl = (s * longint'(gain_q12)) >>> STRENGTH_FRAC;
					if (bl > unit)
						bl = unit;
					// quarter turn, direction from the divergence sign
					if (p.divergence >= 0) begin
						px = -longint'(p.vel_y);
						py = longint'(p.vel_x);
					end else begin
						px = longint'(p.vel_y);
						py = -longint'(p.vel_x);
					end
					r.swirl_x = sat16((px * bl) >>> BLEND_BITS);
					r.swirl_y = sat16((py * bl) >>> BLEND_BITS);
					r.blend = bl[16:0];
				end
				swirl_due.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic report_field(input string name, input int want, input int got);
		n_err++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
	endtask

	// driver: a new transfer is offered only once the previous one was taken
	always @(negedge clk) begin
		if (arst_n && n_offered == n_taken) begin
			if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
				pix <= pending.pop_front();
				pix_valid <= 1'b1;
				n_offered++;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off to back up the block
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (!hold_done && n_taken >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// monitor: checks result transfers, predicts on input transfers
	always @(posedge clk) begin : monitor
		dsf_res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (swirl_due.size() == 0) begin
					n_err++;
					$display("%0t: unexpected result, expected none, got %h", $time, res);
				end else begin
					want = swirl_due.pop_front();
					if (res.swirl_x !== want.swirl_x)
						report_field("swirl_x", want.swirl_x, res.swirl_x);
					if (res.swirl_y !== want.swirl_y)
						report_field("swirl_y", want.swirl_y, res.swirl_y);
					if (res.blend !== want.blend)
						report_field("blend", want.blend, res.blend);
				end
			end
			if (pix_valid && !pix_stall) begin
				track_pixel(pix);
				n_taken++;
			end
		end
	end

	function automatic dsf_pix_t mk_pix(input logic [1:0] op, input logic [15:0] vx,
			input logic [15:0] vy, input logic [15:0] d, input logic ok);
		dsf_pix_t p;
		p.opcode = op;
		p.vel_x = vx;
		p.vel_y = vy;
		p.divergence = d;
		p.pixel_valid = ok;
		return p;
	endfunction

	function automatic logic [15:0] rnd_sample();
		logic [15:0] v;
		int sh;
		case ($urandom_range(5))
			0: v = 16'($urandom);
			1: begin
				case ($urandom_range(3))
					0: v = 16'h8000;
					1: v = 16'h7FFF;
					2: v = 16'h0000;
					default: v = 16'hFFFF;
				endcase
			end
			default: begin
				sh = $urandom_range(1, 15);
				v = 16'($urandom & ((1 << sh) - 1));
				if ($urandom_range(1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	// one frame: a single random item, or an optional clear, up to six measures, then transforms
	task automatic push_frame(inout int cnt);
		logic [1:0] op;
		int nm, nt;
		if ($urandom_range(99) < 12) begin
			op = 2'($urandom_range(3));
			pending.push_back(mk_pix(op, rnd_sample(), rnd_sample(), rnd_sample(),
				1'($urandom_range(1))));
			if (op != OP_UNUSED)
				cnt++;
		end else begin
			if ($urandom_range(3) != 0) begin
				pending.push_back(mk_pix(OP_CLEAR, rnd_sample(), rnd_sample(), rnd_sample(),
					1'($urandom_range(1))));
				cnt++;
			end
			nm = $urandom_range(0, 6);
			nt = $urandom_range(1, 10);
			repeat (nm)
				pending.push_back(mk_pix(OP_MEASURE, rnd_sample(), rnd_sample(), rnd_sample(),
					1'($urandom_range(1))));
			repeat (nt)
				pending.push_back(mk_pix(OP_TRANSFORM, rnd_sample(), rnd_sample(), rnd_sample(),
					1'($urandom_range(9) != 0)));
			cnt += nm + nt;
		end
	endtask

	task automatic wait_quiet();
		while (pending.size() != 0 || n_offered != n_taken || swirl_due.size() != 0)
			@(posedge clk);
		// clear and measure leave no result behind, so give the block time to settle
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [15:0] gains[6];
		int cnt;
		gains = '{16'hFFFF, 16'h0000, 16'($urandom), 16'd4096, 16'd1, 16'($urandom)};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: default peak, saturation, masking, unused opcode, clamp above peak
		pending.push_back(mk_pix(OP_TRANSFORM, 16'h0100, 16'hFE00, 16'h0080, 1'b1));
		pending.push_back(mk_pix(OP_TRANSFORM, 16'h7FFF, 16'h8000, 16'hFF00, 1'b1));
		pending.push_back(mk_pix(OP_TRANSFORM, 16'h8000, 16'h8000, 16'hFF00, 1'b1));
		pending.push_back(mk_pix(OP_TRANSFORM, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
		pending.push_back(mk_pix(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b1));
		pending.push_back(mk_pix(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b0));
		pending.push_back(mk_pix(OP_MEASURE, 16'h0000, 16'h0000, 16'h8000, 1'b1));
		pending.push_back(mk_pix(OP_MEASURE, 16'h0000, 16'h0000, 16'h0064, 1'b1));
		pending.push_back(mk_pix(OP_TRANSFORM, 16'h8000, 16'h8000, 16'h7FFF, 1'b1));
		pending.push_back(mk_pix(OP_TRANSFORM, 16'h7FFF, 16'h8000, 16'h8000, 1'b1));
		pending.push_back(mk_pix(OP_TRANSFORM, 16'h1234, 16'hEDCB, 16'h0000, 1'b1));
		pending.push_back(mk_pix(OP_TRANSFORM, 16'h0400, 16'hFC00, 16'h4000, 1'b1));
		pending.push_back(mk_pix(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		pending.push_back(mk_pix(OP_MEASURE, 16'h0000, 16'h0000, 16'h03E8, 1'b0));
		pending.push_back(mk_pix(OP_TRANSFORM, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
		pending.push_back(mk_pix(OP_TRANSFORM, 16'hC000, 16'h4000, 16'hFE0C, 1'b1));
		pending.push_back(mk_pix(OP_TRANSFORM, 16'h8000, 16'h8000, 16'h8000, 1'b0));
		pending.push_back(mk_pix(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b0));
		pending.push_back(mk_pix(OP_MEASURE, 16'h0000, 16'h0000, 16'h0000, 1'b1));
		pending.push_back(mk_pix(OP_TRANSFORM, 16'h0100, 16'h0100, 16'h0080, 1'b1));
		pending.push_back(mk_pix(OP_TRANSFORM, 16'h0100, 16'h0100, 16'hFF80, 1'b1));
		pending.push_back(mk_pix(OP_UNUSED, 16'h0000, 16'h0000, 16'h0000, 1'b0));
		pending.push_back(mk_pix(OP_TRANSFORM, 16'hFFFF, 16'h0001, 16'h0001, 1'b1));

		for (int seg = 0; seg < 6; seg++) begin
			wait_quiet();
			@(negedge clk);
			cfg_wdata <= gains[seg];
			cfg_we <= 1'b1;
			@(negedge clk);
			cfg_we <= 1'b0;
			gain_q12 = gains[seg];
			case (seg / 2)
				0: begin send_idle = 17; recv_idle = 60; end
				1: begin send_idle = 60; recv_idle = 17; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			cnt = 0;
			while (cnt < SEG_ITEMS)
				push_frame(cnt);
		end

		wait_quiet();
		if (n_err == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
rtl/dsf_pkg.sv
rtl/dsf_front.sv
rtl/dsf_queue.sv
rtl/dsf_back.sv
rtl/divergence_swirl_field_core.sv
dv/divergence_swirl_field_core_test.sv
